[src/fsts_pkg.sv]
// Shared types, character and type codes, and the conversion classifier.
package fsts_pkg;

    localparam int CFG_ADDR_W = 3;

    // Register word index on the configuration port
    localparam logic REG_SIZE_IS_64 = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PCT  = 3'd1,
        PH_SKIP = 3'd2,
        PH_CONV = 3'd3,
        PH_IPFX = 3'd4,
        PH_I3   = 3'd5,
        PH_I6   = 3'd6
    } t_phase;

    localparam logic [3:0] TC_NONE     = 4'd0;
    localparam logic [3:0] TC_UNKNOWN  = 4'd1;
    localparam logic [3:0] TC_CHARPTR  = 4'd2;
    localparam logic [3:0] TC_WCHARPTR = 4'd3;
    localparam logic [3:0] TC_FLOAT    = 4'd4;
    localparam logic [3:0] TC_PTRINT   = 4'd5;
    localparam logic [3:0] TC_PTRVOID  = 4'd6;
    localparam logic [3:0] TC_INT32    = 4'd7;
    localparam logic [3:0] TC_INT64    = 4'd8;
    localparam logic [3:0] TC_UINT32   = 4'd9;
    localparam logic [3:0] TC_UINT64   = 4'd10;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_UP_I  = 8'h49;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [7:0] format_char;
        logic       string_last;
    } t_in_req;

    typedef struct packed {
        logic [3:0] type_code;
        logic       end_of_string;
        logic       last_of_run;
    } t_out_res;

    // One queued request: one or two results, eos belongs to the final one
    typedef struct packed {
        logic       two;
        logic [3:0] code0;
        logic [3:0] code1;
        logic       eos;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= CH_UP_A) && (b <= CH_UP_Z);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return is_upper(b) || ((b >= CH_LO_A) && (b <= CH_LO_Z));
    endfunction

    function automatic logic [3:0] classify(input logic [7:0] b, input logic wide,
                                            input logic size64);
        logic [7:0] lc;
        logic [3:0] code;
        lc = is_upper(b) ? b + CASE_OFS : b;
        unique case (lc)
            8'h63, 8'h64, 8'h69, 8'h6F: code = wide ? TC_INT64 : TC_INT32;   // c d i o
            8'h75, 8'h78:               code = wide ? TC_UINT64 : TC_UINT32; // u x
            8'h7A:                      code = size64 ? TC_UINT64 : TC_UINT32; // z
            8'h65, 8'h66, 8'h67:        code = TC_FLOAT;                     // e f g
            8'h6E:                      code = TC_PTRINT;                    // n
            8'h70:                      code = TC_PTRVOID;                   // p
            8'h73:                      code = (b == CH_UP_S) ? TC_WCHARPTR : TC_CHARPTR;
            default:                    code = TC_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

[src/fsts_front.sv]
// Front end: phase machine that classifies each accepted byte into a queued request.
module fsts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  fsts_pkg::t_in_req i_req,
    input  logic              i_size_is_64,
    output logic              o_push,
    output fsts_pkg::t_q_entry o_entry
);
    import fsts_pkg::*;

    t_phase r_phase, n_phase;
    logic   r_wide, n_wide;

    t_phase     mid_phase;
    logic       mid_wide;
    logic       r1_valid;
    logic [3:0] r1_code;
    logic [7:0] b;
    logic       skip_path;

    assign b = i_req.format_char;

    // Per-byte step before end-of-string handling
    always_comb begin
        mid_phase = r_phase;
        mid_wide  = r_wide;
        r1_valid  = 1'b0;
        r1_code   = TC_UNKNOWN;
        skip_path = 1'b0;
        unique case (r_phase)
            PH_PCT: begin
                if (b == CH_PCT) begin
                    mid_phase = PH_IDLE;
                end else begin
                    mid_phase = PH_SKIP;
                    skip_path = 1'b1;
                end
            end
            PH_SKIP: skip_path = 1'b1;
            PH_CONV: begin
                r1_valid  = 1'b1;
                r1_code   = classify(b, r_wide, i_size_is_64);
                mid_phase = PH_IDLE;
            end
            PH_IPFX: begin
                if (b == CH_3) begin
                    mid_phase = PH_I3;
                end else if (b == CH_6) begin
                    mid_phase = PH_I6;
                end else begin
                    mid_wide  = i_size_is_64;
                    r1_valid  = 1'b1;
                    r1_code   = classify(b, i_size_is_64, i_size_is_64);
                    mid_phase = PH_IDLE;
                end
            end
            PH_I3, PH_I6: begin
                if ((r_phase == PH_I3 && b == CH_2) || (r_phase == PH_I6 && b == CH_4)) begin
                    mid_wide  = (r_phase == PH_I6);
                    mid_phase = PH_CONV;
                end else begin
                    // broken modifier: report it, then rescan this byte
                    r1_valid  = 1'b1;
                    r1_code   = TC_UNKNOWN;
                    mid_phase = (b == CH_PCT) ? PH_PCT : PH_IDLE;
                end
            end
            default: mid_phase = (b == CH_PCT) ? PH_PCT : PH_IDLE;
        endcase
        if (skip_path && is_letter(b)) begin
            if (b == CH_H || b == CH_L || b == CH_W) begin
                mid_wide  = 1'b0;
                mid_phase = PH_CONV;
            end else if (b == CH_UP_I) begin
                mid_phase = PH_IPFX;
            end else begin
                r1_valid  = 1'b1;
                r1_code   = classify(b, 1'b0, i_size_is_64);
                mid_phase = PH_IDLE;
            end
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_wide  = r_wide;
        if (i_accept) begin
            n_phase = i_req.string_last ? PH_IDLE : mid_phase;
            n_wide  = i_req.string_last ? 1'b0 : mid_wide;
        end
    end

    // Request built for the back end
    always_comb begin
        logic       dangling;
        logic [3:0] end_code;
        dangling = (mid_phase == PH_I3) || (mid_phase == PH_I6);
        end_code = (mid_phase == PH_IDLE) ? TC_NONE : TC_UNKNOWN;
        o_entry  = '{two: 1'b0, code0: r1_code, code1: TC_NONE, eos: 1'b0};
        o_push   = i_accept && (r1_valid || i_req.string_last);
        if (i_req.string_last) begin
            o_entry.eos = 1'b1;
            if (r1_valid) begin
                o_entry.two   = 1'b1;
                o_entry.code1 = end_code;
            end else if (dangling) begin
                o_entry.two   = 1'b1;
                o_entry.code0 = TC_UNKNOWN;
                o_entry.code1 = TC_NONE;
            end else begin
                o_entry.code0 = end_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wide  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_wide  <= n_wide;
        end
    end

endmodule

[src/fsts_queue.sv]
// Small FIFO of classified requests between front and back end.
module fsts_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fsts_pkg::t_q_entry  i_wdata,
    input  logic                i_pop,
    output fsts_pkg::t_q_entry  o_rdata,
    output fsts_pkg::t_q_status o_status
);
    import fsts_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_rdata        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

[src/fsts_back.sv]
// Back end: splits queued requests into single results behind an output register.
module fsts_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsts_pkg::t_q_entry  i_head,
    input  fsts_pkg::t_q_status i_status,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output fsts_pkg::t_out_res  o_out_data
);
    import fsts_pkg::*;

    logic     r_sub, n_sub;          // 1 while the second result of the head is pending
    logic     r_valid, n_valid;
    t_out_res r_data, n_data;
    logic     load;
    logic     final_sub;

    assign load      = !i_status.empty && (!r_valid || !i_out_stall);
    assign final_sub = r_sub || !i_head.two;
    assign o_pop     = load && final_sub;

    always_comb begin
        n_sub   = r_sub;
        n_valid = r_valid && i_out_stall;
        n_data  = r_data;
        if (load) begin
            n_valid              = 1'b1;
            n_sub                = !final_sub;
            n_data.type_code     = r_sub ? i_head.code1 : i_head.code0;
            n_data.end_of_string = final_sub && i_head.eos;
            n_data.last_of_run   = final_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_sub   <= n_sub;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    a_sub_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> !i_status.empty && i_head.two)
        else $error("second result pending without a two-result request");
    a_second_follows_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !final_sub) |=> r_valid && !r_data.last_of_run)
        else $error("first of two results not presented");

endmodule

[src/format_spec_type_scanner.sv]
// Top level of the printf format spec type scanner.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | request   | i_in_valid / o_in_stall    | i_in_data  (format_char, string_last)
//  out     | result    | o_out_valid / i_out_stall  | o_out_data (type_code, eos, last)
//  cfg     | APB rd/wr | psel/penable/pwrite/pready | paddr, pwdata, prdata (size_is_64)
//
// One byte is accepted per cycle while the request queue has room.  A byte that
// yields two results (a result on the final byte, or a string ending inside
// I3/I6) holds the single output register for both results in turn; the queue absorbs that.
// A byte's first result goes through the queue entry, written at the accepting edge,
// and then the output register, which loads only when it is empty or not stalled.
// Reset is synchronous, active low: phase idle, queue empty, size_is_64 = 1.
// Input and output stall independently; o_in_stall rises only when the queue is full.
module format_spec_type_scanner #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fsts_pkg::t_in_req               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fsts_pkg::t_out_res              o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fsts_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import fsts_pkg::*;

    logic      r_size_is_64;
    logic      cfg_wr;
    logic      in_accept;
    logic      push;
    logic      pop;
    t_q_entry  wr_entry;
    t_q_entry  head;
    t_q_status q_status;

    // Config register: word index is the address bit above the byte offset
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SIZE_IS_64) ? {31'd0, r_size_is_64} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_is_64 <= 1'b1;
        end else if (cfg_wr && paddr[2] == REG_SIZE_IS_64) begin
            r_size_is_64 <= pwdata[0];
        end
    end

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    fsts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_req        (i_in_data),
        .i_size_is_64 (r_size_is_64),
        .o_push       (push),
        .o_entry      (wr_entry)
    );

    fsts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (wr_entry),
        .i_pop    (pop),
        .o_rdata  (head),
        .o_status (q_status)
    );

    fsts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (q_status),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[bench/tb_format_spec_type_scanner.sv]
// Self-checking testbench for format_spec_type_scanner: directed rows, then random strings.
module tb_format_spec_type_scanner;
    import fsts_pkg::*;

    // Random receiver and sender gaps: percent chance that a cycle is idle
    localparam int IDLE_PCT    = 27;
    // Receiver hold-off long enough to fill the request queue and back up the input
    localparam int HOLD_CYCLES = 300;
    // Cycles allowed after the last expected result before the block counts as idle
    localparam int DRAIN_WAIT  = 8;
    localparam int N_ROWS      = 32;
    localparam logic [CFG_ADDR_W-1:0] SIZE64_ADDR = {REG_SIZE_IS_64, 2'b00};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_req            i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_res           o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    format_spec_type_scanner DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the scanner: phase, pending width, and the size register
    t_phase     scan_ph;
    logic       scan_wide;
    logic       scan_size64;

    // Type results still owed by the block, oldest first
    t_out_res   pending_types [$];
    int         err_count  = 0;
    int         bytes_sent = 0;
    bit         quiet_mode = 1'b0;   // no gaps on either side
    bit         hold_req   = 1'b0;   // receiver holds off for HOLD_CYCLES

    string      flag_chars = "-+ #0123456789.*";
    string      conv_chars = "cdiouxzefgnpsS";

    // Directed rows. Where typed is set, the row's results are spelled out here
    // (count and the first code); other rows take what the shadow scanner says.
    typedef struct {
        logic [7:0] ch;
        bit         last;
        bit         typed;
        int         cnt;
        logic [3:0] code;
    } t_row;

    t_row dir_rows [N_ROWS] = '{
        '{"q",     1'b0, 1'b1, 0, TC_NONE},      // letter outside a spec
        '{8'h00,   1'b0, 1'b1, 0, TC_NONE},      // zero byte is just a byte
        '{"%",     1'b0, 1'b1, 0, TC_NONE},
        '{"%",     1'b0, 1'b1, 0, TC_NONE},      // doubled percent: literal
        '{"%",     1'b0, 1'b1, 0, TC_NONE},
        '{"-",     1'b0, 1'b1, 0, TC_NONE},      // flag skipped
        '{8'hFF,   1'b0, 1'b1, 0, TC_NONE},      // top byte, non-letter, skipped
        '{"l",     1'b0, 1'b1, 0, TC_NONE},
        '{"x",     1'b0, 1'b1, 1, TC_UINT32},    // l is not wide
        '{"%",     1'b0, 1'b1, 0, TC_NONE},
        '{"I",     1'b0, 1'b1, 0, TC_NONE},
        '{"6",     1'b0, 1'b1, 0, TC_NONE},
        '{"4",     1'b0, 1'b1, 0, TC_NONE},
        '{"d",     1'b0, 1'b1, 1, TC_INT64},     // I64 forces wide
        '{"%",     1'b0, 1'b0, 0, TC_NONE},
        '{"I",     1'b0, 1'b0, 0, TC_NONE},
        '{"3",     1'b0, 1'b0, 0, TC_NONE},
        '{"7",     1'b0, 1'b1, 1, TC_UNKNOWN},   // broken I3, byte rescanned
        '{"%",     1'b0, 1'b0, 0, TC_NONE},
        '{"h",     1'b0, 1'b0, 0, TC_NONE},
        '{".",     1'b0, 1'b1, 1, TC_UNKNOWN},   // non-letter after modifier
        '{"%",     1'b0, 1'b0, 0, TC_NONE},
        '{"I",     1'b0, 1'b0, 0, TC_NONE},
        '{"u",     1'b0, 1'b0, 0, TC_NONE},      // bare I, width from register
        '{"%",     1'b0, 1'b0, 0, TC_NONE},
        '{"S",     1'b0, 1'b1, 1, TC_WCHARPTR},
        '{"%",     1'b0, 1'b0, 0, TC_NONE},
        '{"I",     1'b0, 1'b0, 0, TC_NONE},
        '{"6",     1'b1, 1'b0, 0, TC_NONE},      // string ends inside I6: two results
        '{"%",     1'b1, 1'b1, 1, TC_UNKNOWN},   // string ends on an open spec
        '{"%",     1'b0, 1'b0, 0, TC_NONE},
        '{"e",     1'b1, 1'b0, 0, TC_NONE}       // conversion on the final byte
    };

    // Argument type of a conversion letter, case-insensitive apart from S
    function automatic logic [3:0] conv_type(input logic [7:0] b, input logic wide);
        logic [7:0] lc;
        lc = (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
        case (lc)
            "c", "d", "i", "o": return wide ? TC_INT64 : TC_INT32;
            "u", "x":           return wide ? TC_UINT64 : TC_UINT32;
            "z":                return scan_size64 ? TC_UINT64 : TC_UINT32;
            "e", "f", "g":      return TC_FLOAT;
            "n":                return TC_PTRINT;
            "p":                return TC_PTRVOID;
            "s":                return (b == "S") ? TC_WCHARPTR : TC_CHARPTR;
            default:            return TC_UNKNOWN;
        endcase
    endfunction

    // Advance the shadow scanner by one byte; returns how many types it yields
    function automatic int scan_byte(input t_in_req r, output logic [3:0] c0,
                                     output logic [3:0] c1);
        logic [7:0] b;
        logic       rescan;
        int         n;
        b      = r.format_char;
        rescan = 1'b0;
        n      = 0;
        c0     = TC_NONE;
        c1     = TC_NONE;
        case (scan_ph)
            PH_PCT, PH_SKIP: begin
                if (scan_ph == PH_PCT && b == CH_PCT) begin
                    scan_ph = PH_IDLE;
                end else begin
                    scan_ph = PH_SKIP;
                    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
                        if (b == CH_H || b == CH_L || b == CH_W) begin
                            scan_wide = 1'b0;
                            scan_ph   = PH_CONV;
                        end else if (b == CH_UP_I) begin
                            scan_ph = PH_IPFX;
                        end else begin
                            c0      = conv_type(b, 1'b0);
                            n       = 1;
                            scan_ph = PH_IDLE;
                        end
                    end
                end
            end
            PH_CONV: begin
                c0      = conv_type(b, scan_wide);
                n       = 1;
                scan_ph = PH_IDLE;
            end
            PH_IPFX: begin
                if (b == CH_3) begin
                    scan_ph = PH_I3;
                end else if (b == CH_6) begin
                    scan_ph = PH_I6;
                end else begin
                    scan_wide = scan_size64;
                    c0        = conv_type(b, scan_wide);
                    n         = 1;
                    scan_ph   = PH_IDLE;
                end
            end
            PH_I3, PH_I6: begin
                if ((scan_ph == PH_I3 && b == CH_2) || (scan_ph == PH_I6 && b == CH_4)) begin
                    scan_wide = (scan_ph == PH_I6);
                    scan_ph   = PH_CONV;
                end else begin
                    c0     = TC_UNKNOWN;
                    n      = 1;
                    rescan = 1'b1;
                end
            end
            default: rescan = 1'b1;
        endcase
        if (rescan)
            scan_ph = (b == CH_PCT) ? PH_PCT : PH_IDLE;
        if (r.string_last) begin
            // a string cut inside I3/I6 owes the broken modifier first
            if (scan_ph == PH_I3 || scan_ph == PH_I6) begin
                c0 = TC_UNKNOWN;
                c1 = TC_NONE;
                n  = 2;
            end else begin
                if (n == 0)
                    c0 = (scan_ph == PH_IDLE) ? TC_NONE : TC_UNKNOWN;
                else
                    c1 = (scan_ph == PH_IDLE) ? TC_NONE : TC_UNKNOWN;
                n = n + 1;
            end
            scan_ph   = PH_IDLE;
            scan_wide = 1'b0;
        end
        return n;
    endfunction

    // Offer one byte, wait until the block takes it, then book its results
    task automatic drive_byte(input logic [7:0] ch, input logic last, input bit typed,
                              input int cnt, input logic [3:0] code);
        t_in_req    req;
        t_out_res   e;
        logic [3:0] c0, c1;
        int         n;
        req.format_char = ch;
        req.string_last = last;
        if (!quiet_mode) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        n = scan_byte(req, c0, c1);
        if (typed) begin
            n  = cnt;
            c0 = code;
        end
        for (int k = 0; k < n; k++) begin
            e.type_code     = (k == 0) ? c0 : c1;
            e.end_of_string = (k == n - 1) && last;
            e.last_of_run   = (k == n - 1);
            pending_types.push_back(e);
        end
        bytes_sent++;
    endtask

    // Drop valid, wait for every owed result, then give the block time to go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_types.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // APB write of size_is_64, then read it back
    task automatic write_size64(input logic v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= SIZE64_ADDR;
        pwdata  <= {31'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        scan_size64 = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[0] !== v) begin
            $error("size_is_64 readback: expected %0d, got %0d", v, prdata[0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random format strings. Most segments are well-formed specs with random
    // flags, modifiers and conversions; the rest are literal text, doubled
    // percents, raw bytes, broken I3/I6 and strings cut off mid-spec.
    task automatic run_random(input int n_bytes);
        logic [7:0] fmt [$];
        logic [7:0] c;
        int         stop, nseg, cut;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop) begin
            fmt.delete();
            nseg = $urandom_range(1, 4);
            repeat (nseg) begin
                case ($urandom_range(0, 9))
                    0, 1: repeat ($urandom_range(1, 3)) begin
                        do c = 8'($urandom_range(0, 255)); while (c == CH_PCT);
                        fmt.push_back(c);
                    end
                    2: begin
                        fmt.push_back(CH_PCT);
                        fmt.push_back(CH_PCT);
                    end
                    3: fmt.push_back(8'($urandom_range(0, 255)));
                    default: begin
                        fmt.push_back(CH_PCT);
                        repeat ($urandom_range(0, 2))
                            fmt.push_back(flag_chars[$urandom_range(0, flag_chars.len() - 1)]);
                        case ($urandom_range(0, 7))
                            1: fmt.push_back(CH_H);
                            2: fmt.push_back(CH_L);
                            3: fmt.push_back(CH_W);
                            4: fmt.push_back(CH_UP_I);
                            5: begin
                                fmt.push_back(CH_UP_I);
                                fmt.push_back(CH_3);
                                fmt.push_back(CH_2);
                            end
                            6: begin
                                fmt.push_back(CH_UP_I);
                                fmt.push_back(CH_6);
                                fmt.push_back(CH_4);
                            end
                            7: begin
                                // the conversion byte that follows breaks the modifier
                                fmt.push_back(CH_UP_I);
                                fmt.push_back($urandom_range(0, 1) ? CH_3 : CH_6);
                            end
                            default: ;
                        endcase
                        case ($urandom_range(0, 5))
                            0: c = 8'($urandom_range(0, 255));
                            1: c = conv_chars[$urandom_range(0, conv_chars.len() - 1)]
                                   & ~CASE_OFS;
                            default: c = conv_chars[$urandom_range(0, conv_chars.len() - 1)];
                        endcase
                        fmt.push_back(c);
                    end
                endcase
            end
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, fmt.size());
                while (fmt.size() > cut)
                    void'(fmt.pop_back());
            end
            foreach (fmt[k])
                drive_byte(fmt[k], k == fmt.size() - 1, 1'b0, 0, TC_NONE);
        end
    endtask

    // Receiver: random stall, none in quiet stretches, or a long counted hold-off
    initial begin : out_stall_drv
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (quiet_mode || !i_rst_n) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Each accepted result against the oldest owed one, field by field
    always @(posedge i_clk) begin : result_check
        t_out_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_types.size() == 0) begin
                $error("unexpected result: type_code %0d", o_out_data.type_code);
                err_count++;
            end else begin
                want = pending_types.pop_front();
                if (o_out_data.type_code !== want.type_code) begin
                    $error("type_code: expected %0d, got %0d",
                           want.type_code, o_out_data.type_code);
                    err_count++;
                end
                if (o_out_data.end_of_string !== want.end_of_string) begin
                    $error("end_of_string: expected %0d, got %0d",
                           want.end_of_string, o_out_data.end_of_string);
                    err_count++;
                end
                if (o_out_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, o_out_data.last_of_run);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        scan_ph     = PH_IDLE;
        scan_wide   = 1'b0;
        scan_size64 = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows with the register at its reset value
        foreach (dir_rows[k])
            drive_byte(dir_rows[k].ch, dir_rows[k].last, dir_rows[k].typed,
                       dir_rows[k].cnt, dir_rows[k].code);
        run_random(250);
        settle();

        // 32-bit size type, no gaps on either side
        write_size64(1'b0);
        quiet_mode = 1'b1;
        run_random(300);
        settle();

        // 64-bit size type; receiver holds off while the sender keeps offering
        write_size64(1'b1);
        hold_req = 1'b1;
        run_random(100);
        settle();
        quiet_mode = 1'b0;

        write_size64(1'b0);
        run_random(350);
        settle();

        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
